// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. All checks sample on clk and are
// suspended while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every sampled edge.
`define BBA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
package bba_pkg;

  localparam int BLOCK_ID_W = 15;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 16;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic                  func;
    logic [BLOCK_ID_W-1:0] block_id;
  } bba_in_t;

  typedef struct packed {
    logic [BLOCK_ID_W-1:0] granted_block;
    logic [STATUS_W-1:0]   status;
  } bba_out_t;

endpackage

// ===== rtl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// First-fit block allocator over a one-bit-per-block map held in a single
// synchronous RAM of ceil(NUM_BLOCKS/WORD_BITS) words (1024 words of 32 bits by
// default). After reset the block runs a clearing pass of one word per cycle
// and takes no item until it ends; the reserved_count register
// (cfg_we/cfg_wdata) may be written at any time while idle. One item is
// processed at a time. A free passes the divide, read, evaluate and response
// states; one that is ignored, or an allocate on a map already known to be
// full, goes from divide straight to response. An allocate reads k map words,
// one per cycle, in a scan that starts at a register that tracks the lowest
// word that may still hold a free block. A new item is taken as soon as the
// previous result has been moved into the output register.
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = 32768,
  parameter int WORD_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bba_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bba_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  `include "assert_macros.svh"

  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int HW        = $clog2(MAP_WORDS + 1);
  localparam int BW        = $clog2(WORD_BITS);
  localparam int GW        = (AW + 7 > BLOCK_ID_W) ? AW + 7 : BLOCK_ID_W;
  localparam int LAST_BITS = NUM_BLOCKS - (MAP_WORDS - 1) * WORD_BITS;
  localparam int DIV_SHIFT = BLOCK_ID_W + BW;
  localparam int RECIP     = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW        = DIV_SHIFT + AW;

  localparam logic [AW-1:0]        LAST_ADDR = AW'(MAP_WORDS - 1);
  localparam logic [HW-1:0]        HINT_FULL = HW'(MAP_WORDS);
  localparam logic [WORD_BITS-1:0] ONE_W     = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] LAST_PAD  = ~((ONE_W << LAST_BITS) - ONE_W);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic [HW-1:0]         hint_r, hint_nxt;
  logic [BW-1:0]         bit_r, bit_nxt;
  logic [CFG_W-1:0]      reserved_r;
  logic                  func_r;
  logic [BLOCK_ID_W-1:0] id_r;
  bba_out_t              res_r, res_nxt;
  bba_out_t              out_item_r;
  logic                  out_valid_r;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0]  mem_wdata, mem_rdata;

  logic [WORD_BITS-1:0]  scan_word;
  logic                  ffz_found;
  logic [BW-1:0]         ffz_idx;

  logic                  in_xfer, load_out, free_bad;
  logic [PW-1:0]         quot_prod;
  logic [GW-1:0]         word_base, grant_blk;

  bba_map_mem #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // blocks past the end of the map look allocated
  assign scan_word = mem_rdata | ((addr_r == LAST_ADDR) ? LAST_PAD : '0);

  bba_ffz #(
    .WIDTH (WORD_BITS),
    .BW    (BW)
  ) u_ffz (
    .word  (scan_word),
    .found (ffz_found),
    .idx   (ffz_idx)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign load_out  = (state_r == S_RESP) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign free_bad  = ({1'b0, id_r} < reserved_r) || (32'(id_r) >= 32'(NUM_BLOCKS));
  // word index of a free by reciprocal multiply
  assign quot_prod = PW'(id_r) * PW'(RECIP);
  assign word_base = GW'(addr_r) * GW'(WORD_BITS);
  assign grant_blk = word_base + GW'(ffz_idx);

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    hint_nxt  = hint_r;
    bit_nxt   = bit_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = addr_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        res_nxt.granted_block = '0;
        if (func_r == FUNC_ALLOC) begin
          if (hint_r == HINT_FULL) begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_RESP;
          end else begin
            addr_nxt  = hint_r[AW-1:0];
            state_nxt = S_RD;
          end
        end else if (free_bad) begin
          res_nxt.status = ST_IGNORED;
          state_nxt      = S_RESP;
        end else begin
          addr_nxt  = quot_prod[DIV_SHIFT +: AW];
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        bit_nxt   = BW'(GW'(id_r) - word_base);
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (func_r == FUNC_FREE) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata & ~(ONE_W << bit_r);
          if (HW'(addr_r) < hint_r) begin
            hint_nxt = HW'(addr_r);
          end
          res_nxt.granted_block = '0;
          res_nxt.status        = ST_DONE;
          state_nxt             = S_RESP;
        end else if (ffz_found) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | (ONE_W << ffz_idx);
          hint_nxt  = HW'(addr_r);
          res_nxt.granted_block = grant_blk[BLOCK_ID_W-1:0];
          res_nxt.status        = ST_DONE;
          state_nxt             = S_RESP;
        end else if (addr_r == LAST_ADDR) begin
          hint_nxt              = HINT_FULL;
          res_nxt.granted_block = '0;
          res_nxt.status        = ST_FULL;
          state_nxt             = S_RESP;
        end else begin
          // advance the scan; next word lands in the read register
          addr_nxt  = addr_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = addr_r + 1'b1;
        end
      end
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      hint_r      <= '0;
      reserved_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      hint_r  <= hint_nxt;
      if (cfg_we) begin
        reserved_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
    res_r <= res_nxt;
    if (in_xfer) begin
      func_r <= in_data.func;
      id_r   <= in_data.block_id;
    end
    if (load_out) begin
      out_item_r <= res_r;
    end
  end

  `BBA_ASSERT_ALWAYS(a_hint_bound, hint_r <= HINT_FULL, "scan hint beyond map")
  `BBA_ASSERT_IMPLIES(a_no_write_idle, (state_r == S_IDLE) || (state_r == S_RESP), !mem_we, "map written outside update")
  `BBA_ASSERT_IMPLIES(a_scan_above_hint, (state_r == S_EVAL) && (func_r == FUNC_ALLOC), HW'(addr_r) >= hint_r, "scan below hint")
  `BBA_ASSERT_NEXT(a_eval_read, (state_r == S_RD), (state_r == S_EVAL) && $past(mem_re), "evaluation without read")

endmodule

// ===== rtl/bba_map_mem.sv =====
`timescale 1ns / 1ps
module bba_map_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bba_ffz.sv =====
`timescale 1ns / 1ps
module bba_ffz #(
  parameter int WIDTH = 32,
  parameter int BW    = 5
) (
  input  logic [WIDTH-1:0] word,
  output logic             found,
  output logic [BW-1:0]    idx
);

  localparam int NG   = (WIDTH + 7) / 8;
  localparam int PADW = NG * 8;

  logic [PADW-1:0] padded;
  logic [NG-1:0]   grp_zero;
  logic [2:0]      grp_idx [NG];
  logic [2:0]      sel_g;
  logic [2:0]      sel_i;

  // bits past the word read as in use
  assign padded = ~(PADW'(~word));

  // first clear bit inside each byte lane
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_zero[g] = 1'b0;
      grp_idx[g]  = 3'd0;
      for (int b = 7; b >= 0; b--) begin
        if (!padded[g*8 + b]) begin
          grp_zero[g] = 1'b1;
          grp_idx[g]  = 3'(b);
        end
      end
    end
  end

  // lowest lane that has a clear bit
  always_comb begin
    found = 1'b0;
    sel_g = 3'd0;
    sel_i = 3'd0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_zero[g]) begin
        found = 1'b1;
        sel_g = 3'(g);
        sel_i = grp_idx[g];
      end
    end
  end

  assign idx = BW'({sel_g, sel_i});

endmodule
